>>> hw/rtl/mp2s_pkg.sv
// ============================================================================
// mp2s_pkg
// Shared constants, register codes and payload types for the streaming
// two-dimensional max-pooling block.
// ============================================================================
package mp2s_pkg;

    // Build-time sizes of the running-maximum store.
    localparam int MAX_OUT_WIDTH = 256;
    localparam int MAX_CHANNELS  = 32;
    localparam int SAMPLE_BITS   = 16;
    localparam int STORE_DEPTH   = MAX_OUT_WIDTH * MAX_CHANNELS;

    // Field widths of the configuration registers.
    localparam int PH_W       = 5;
    localparam int H_W        = 13;
    localparam int W_W        = 9;
    localparam int C_W        = 6;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 3;

    // Limits applied to the configuration registers.
    localparam int POOL_MAX = 16;
    localparam int H_MAX    = 4096;
    localparam int W_MAX    = 256;

    // Reset values of the configuration registers.
    localparam int RST_POOL     = 2;
    localparam int RST_SIZE     = 32;
    localparam int RST_CHANNELS = 1;

    // Position counter widths.
    localparam int ROW_W  = 12;
    localparam int COL_W  = 8;
    localparam int CH_W   = $clog2(MAX_CHANNELS);
    localparam int WIN_W  = 4;
    localparam int OCOL_W = $clog2(MAX_OUT_WIDTH);
    localparam int ADDR_W = OCOL_W + CH_W;

    // Shared divider: four lanes, one quotient bit per cycle.
    localparam int DIV_LANES = 4;
    localparam int DIV_W     = 13;
    localparam int DIVR_W    = 5;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int LANE_H    = 0;
    localparam int LANE_W    = 1;
    localparam int LANE_ROW  = 2;
    localparam int LANE_COL  = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POOL_HEIGHT   = 3'd0,
        CFG_POOL_WIDTH    = 3'd1,
        CFG_IN_HEIGHT     = 3'd2,
        CFG_IN_WIDTH      = 3'd3,
        CFG_CHANNEL_COUNT = 3'd4
    } t_cfg_idx;

    // Configuration after limiting to the legal ranges.
    typedef struct packed {
        logic [PH_W-1:0] ph;
        logic [PH_W-1:0] pw;
        logic [H_W-1:0]  h;
        logic [W_W-1:0]  w;
        logic [C_W-1:0]  c;
    } t_cfg;

    // Window bookkeeping derived by division and kept by the counters.
    typedef struct packed {
        logic [H_W-1:0]   out_h;
        logic [W_W-1:0]   out_w;
        logic [ROW_W-1:0] row_q;
        logic [WIN_W-1:0] row_r;
        logic [COL_W-1:0] col_q;
        logic [WIN_W-1:0] col_r;
    } t_pos;

    // Input transaction payload.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          frame_start;
    } t_in_item;

    // Output transaction payload.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] pooled_value;
        logic                          frame_last;
    } t_out_item;

    // Request from the counters to the read-modify-write stage.
    typedef struct packed {
        logic [ADDR_W-1:0]             addr;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          use_it;
        logic                          first;
        logic                          last;
        logic                          frame_last;
    } t_req;

endpackage

>>> hw/rtl/mp2s_in_if.sv
// ============================================================================
// mp2s_in_if
// Valid/ready channel carrying one input sample per transaction.
// ============================================================================
interface mp2s_in_if;
    import mp2s_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/mp2s_out_if.sv
// ============================================================================
// mp2s_out_if
// Valid/ready channel carrying one pooled value per transaction.
// ============================================================================
interface mp2s_out_if;
    import mp2s_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/mp2s_div.sv
// ============================================================================
// mp2s_div
// Four-lane restoring divider, one quotient bit per lane per cycle. Used to
// derive window positions and output dimensions after a configuration change.
// ============================================================================
module mp2s_div (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_start,
    input  logic [mp2s_pkg::DIV_LANES-1:0][mp2s_pkg::DIV_W-1:0]  i_dividend,
    input  logic [mp2s_pkg::DIV_LANES-1:0][mp2s_pkg::DIVR_W-1:0] i_divisor,
    output logic                                            o_done,
    output logic [mp2s_pkg::DIV_LANES-1:0][mp2s_pkg::DIV_W-1:0]  o_quotient,
    output logic [mp2s_pkg::DIV_LANES-1:0][mp2s_pkg::DIVR_W-1:0] o_remainder
);
    import mp2s_pkg::*;

    logic                                r_run;
    logic                                r_done;
    logic [DIV_CNT_W-1:0]                r_cnt;
    logic [DIV_LANES-1:0][DIV_W-1:0]     r_quo;
    logic [DIV_LANES-1:0][DIVR_W-1:0]    r_rem;
    logic [DIV_LANES-1:0][DIVR_W-1:0]    r_den;
    logic [DIV_LANES-1:0][DIV_W-1:0]     n_quo;
    logic [DIV_LANES-1:0][DIVR_W-1:0]    n_rem;
    logic [DIVR_W:0]                     trial;
    logic                                last_step;

    assign last_step = (r_cnt == DIV_CNT_W'(DIV_W - 1));

    // One restoring step per lane: bring down the next dividend bit and
    // subtract the divisor when it fits.
    always_comb begin
        trial = '0;
        for (int k = 0; k < DIV_LANES; k++) begin
            trial = {r_rem[k], r_quo[k][DIV_W-1]};
            if (trial >= {1'b0, r_den[k]}) begin
                n_rem[k] = DIVR_W'(trial - {1'b0, r_den[k]});
                n_quo[k] = {r_quo[k][DIV_W-2:0], 1'b1};
            end else begin
                n_rem[k] = trial[DIVR_W-1:0];
                n_quo[k] = {r_quo[k][DIV_W-2:0], 1'b0};
            end
        end
    end

    // Step sequencing; a new start always restarts the lanes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_run  <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_run && last_step;
            if (r_run) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (last_step) begin
                    r_run <= 1'b0;
                end
            end
        end
    end

    // Lane data path.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_den <= i_divisor;
            r_rem <= '0;
        end else if (r_run) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

>>> hw/rtl/mp2s_cnt.sv
// ============================================================================
// mp2s_cnt
// Position counters of the input stream. Builds the store address and the
// window flags of each accepted sample and advances row, column and channel.
// ============================================================================
module mp2s_cnt (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mp2s_pkg::t_cfg                  i_cfg,
    input  logic                            i_load,
    input  mp2s_pkg::t_pos                  i_pos,
    input  logic                            i_accept,
    input  mp2s_pkg::t_in_item              i_item,
    output mp2s_pkg::t_req                  o_req,
    output logic [mp2s_pkg::ROW_W-1:0]      o_row,
    output logic [mp2s_pkg::COL_W-1:0]      o_col
);
    import mp2s_pkg::*;

    t_pos             r_pos, n_pos, e_pos;
    logic [ROW_W-1:0] r_row, n_row, e_row;
    logic [COL_W-1:0] r_col, n_col, e_col;
    logic [CH_W-1:0]  r_ch, n_ch, e_ch;
    logic [WIN_W-1:0] r_rw, n_rw, e_rw;
    logic [WIN_W-1:0] r_cw, n_cw, e_cw;

    logic [C_W-1:0]   ch_inc;
    logic [PH_W-1:0]  cw_inc, rw_inc, colr_inc, rowr_inc;
    logic [W_W-1:0]   col_inc;
    logic [H_W-1:0]   row_inc;

    // A frame start clears the position before the sample is used.
    always_comb begin
        e_pos = r_pos;
        e_row = r_row;
        e_col = r_col;
        e_ch  = r_ch;
        e_rw  = r_rw;
        e_cw  = r_cw;
        if (i_item.frame_start) begin
            e_pos.row_q = '0;
            e_pos.row_r = '0;
            e_pos.col_q = '0;
            e_pos.col_r = '0;
            e_row       = '0;
            e_col       = '0;
            e_ch        = '0;
            e_rw        = '0;
            e_cw        = '0;
        end
    end

    // Store address and window flags of the current sample.
    always_comb begin
        o_req.addr   = {OCOL_W'(e_pos.col_q), e_ch};
        o_req.sample = i_item.sample;
        o_req.use_it = ({1'b0, e_pos.row_q} < r_pos.out_h)
                    && ({1'b0, e_pos.col_q} < r_pos.out_w)
                    && ({1'b0, e_ch} < i_cfg.c);
        o_req.first  = (e_rw == '0) && (e_cw == '0);
        o_req.last   = ({1'b0, e_rw} == i_cfg.ph - PH_W'(1))
                    && ({1'b0, e_cw} == i_cfg.pw - PH_W'(1));
        o_req.frame_last = ({1'b0, e_pos.row_q} == r_pos.out_h - H_W'(1))
                        && ({1'b0, e_pos.row_r} == i_cfg.ph - PH_W'(1))
                        && ({1'b0, e_pos.col_q} == r_pos.out_w - W_W'(1))
                        && ({1'b0, e_ch} == i_cfg.c - C_W'(1));
    end

    // Advance channel, then column, then row, each wrapping at its bound.
    always_comb begin
        ch_inc   = {1'b0, e_ch} + C_W'(1);
        cw_inc   = {1'b0, e_cw} + PH_W'(1);
        rw_inc   = {1'b0, e_rw} + PH_W'(1);
        colr_inc = {1'b0, e_pos.col_r} + PH_W'(1);
        rowr_inc = {1'b0, e_pos.row_r} + PH_W'(1);
        col_inc  = {1'b0, e_col} + W_W'(1);
        row_inc  = {1'b0, e_row} + H_W'(1);

        n_pos = r_pos;
        n_row = r_row;
        n_col = r_col;
        n_ch  = r_ch;
        n_rw  = r_rw;
        n_cw  = r_cw;

        if (i_load) begin
            n_pos = i_pos;
        end else if (i_accept) begin
            n_pos = e_pos;
            n_row = e_row;
            n_col = e_col;
            n_rw  = e_rw;
            n_cw  = e_cw;
            n_ch  = ch_inc[CH_W-1:0];
            if (ch_inc >= i_cfg.c) begin
                n_ch = '0;
                if (col_inc >= i_cfg.w) begin
                    // End of the input row.
                    n_col       = '0;
                    n_cw        = '0;
                    n_pos.col_q = '0;
                    n_pos.col_r = '0;
                    n_rw = (rw_inc >= i_cfg.ph) ? '0 : rw_inc[WIN_W-1:0];
                    if (row_inc >= i_cfg.h) begin
                        n_row       = '0;
                        n_rw        = '0;
                        n_pos.row_q = '0;
                        n_pos.row_r = '0;
                    end else begin
                        n_row = row_inc[ROW_W-1:0];
                        if (rowr_inc == i_cfg.ph) begin
                            n_pos.row_r = '0;
                            n_pos.row_q = e_pos.row_q + ROW_W'(1);
                        end else begin
                            n_pos.row_r = rowr_inc[WIN_W-1:0];
                        end
                    end
                end else begin
                    n_col = col_inc[COL_W-1:0];
                    n_cw  = (cw_inc >= i_cfg.pw) ? '0 : cw_inc[WIN_W-1:0];
                    if (colr_inc == i_cfg.pw) begin
                        n_pos.col_r = '0;
                        n_pos.col_q = e_pos.col_q + COL_W'(1);
                    end else begin
                        n_pos.col_r = colr_inc[WIN_W-1:0];
                    end
                end
            end
        end
    end

    // Counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_row <= '0;
            r_col <= '0;
            r_ch  <= '0;
            r_rw  <= '0;
            r_cw  <= '0;
        end else begin
            r_pos <= n_pos;
            r_row <= n_row;
            r_col <= n_col;
            r_ch  <= n_ch;
            r_rw  <= n_rw;
            r_cw  <= n_cw;
        end
    end

    assign o_row = r_row;
    assign o_col = r_col;

endmodule

>>> hw/rtl/mp2s_rmw.sv
// ============================================================================
// mp2s_rmw
// Running-maximum store with a registered read, the compare and write-back
// stage, forwarding of the latest write, and the output register.
// ============================================================================
module mp2s_rmw (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  mp2s_pkg::t_req i_req,
    output logic           o_adv,
    mp2s_out_if.source     o_out
);
    import mp2s_pkg::*;

    logic signed [SAMPLE_BITS-1:0] mem [STORE_DEPTH];

    logic                          r_rd_valid;
    logic signed [SAMPLE_BITS-1:0] r_rd_data;
    t_req                          r_s1;
    logic                          r_wr_valid;
    logic [ADDR_W-1:0]             r_wr_addr;
    logic signed [SAMPLE_BITS-1:0] r_wr_data;
    logic                          r_out_valid;
    t_out_item                     r_out_data;

    logic signed [SAMPLE_BITS-1:0] cur;
    logic signed [SAMPLE_BITS-1:0] upd;
    logic                          fire;
    logic                          wr_en;
    logic                          produce;

    // The stage moves when it is empty or the output register can take a result.
    assign o_adv   = !r_rd_valid || !r_out_valid || o_out.ready;
    assign fire    = r_rd_valid && o_adv;
    assign wr_en   = fire && r_s1.use_it;
    assign produce = wr_en && r_s1.last;

    // The previous write may not be visible in the read data yet.
    always_comb begin
        cur = r_rd_data;
        if (r_wr_valid && (r_wr_addr == r_s1.addr)) begin
            cur = r_wr_data;
        end
        upd = (r_s1.first || (r_s1.sample > cur)) ? r_s1.sample : cur;
    end

    // Store read and write ports.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_rd_data <= mem[i_req.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_s1.addr] <= upd;
        end
    end

    // Stage control and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid  <= 1'b0;
            r_wr_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                r_rd_valid <= 1'b1;
            end else if (fire) begin
                r_rd_valid <= 1'b0;
            end
            if (wr_en) begin
                r_wr_valid <= 1'b1;
            end
            if (produce) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1 <= i_req;
        end
        if (wr_en) begin
            r_wr_addr <= r_s1.addr;
            r_wr_data <= upd;
        end
        if (produce) begin
            r_out_data.pooled_value <= upd;
            r_out_data.frame_last   <= r_s1.frame_last;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

endmodule

>>> hw/rtl/max_pooling_2d_stream_top.sv
// ============================================================================
// max_pooling_2d_stream_top
// Streaming non-overlapping 2-D max pooling over signed Q8.8 samples.
// ============================================================================
// One sample is accepted per clock cycle while the block is not busy, no
// register is being written and the read-modify-write stage can move. The
// store is read at acceptance into the stage register, and the window maximum
// is written back from that stage with the latest write forwarded; a pooled
// value then leaves through the output register. After reset and after every
// configuration write the block holds input ready low while a bit-serial
// divider derives the output dimensions and the current window position. The
// running-maximum store is not cleared: every window loads its entry from its own first sample.
module max_pooling_2d_stream_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [mp2s_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mp2s_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    mp2s_in_if.sink                            i_in,
    mp2s_out_if.source                         o_out
);
    import mp2s_pkg::*;

    logic [PH_W-1:0] r_ph, r_pw;
    logic [H_W-1:0]  r_h;
    logic [W_W-1:0]  r_w;
    logic [C_W-1:0]  r_c;
    logic            r_busy;
    logic            r_kick;

    t_cfg            cfg;
    t_pos            pos;
    t_req            req;
    logic            accept;
    logic            adv;
    logic            load;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;

    logic                               div_done;
    logic [DIV_LANES-1:0][DIV_W-1:0]    div_dividend;
    logic [DIV_LANES-1:0][DIVR_W-1:0]   div_divisor;
    logic [DIV_LANES-1:0][DIV_W-1:0]    div_quo;
    logic [DIV_LANES-1:0][DIVR_W-1:0]   div_rem;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_W'(RST_POOL);
            r_pw <= PH_W'(RST_POOL);
            r_h  <= H_W'(RST_SIZE);
            r_w  <= W_W'(RST_SIZE);
            r_c  <= C_W'(RST_CHANNELS);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_POOL_HEIGHT:   r_ph <= i_cfg_data[PH_W-1:0];
                CFG_POOL_WIDTH:    r_pw <= i_cfg_data[PH_W-1:0];
                CFG_IN_HEIGHT:     r_h  <= i_cfg_data[H_W-1:0];
                CFG_IN_WIDTH:      r_w  <= i_cfg_data[W_W-1:0];
                CFG_CHANNEL_COUNT: r_c  <= i_cfg_data[C_W-1:0];
                default: ;
            endcase
        end
    end

    // Limit each register to its legal range.
    always_comb begin
        cfg.ph = (r_ph == '0) ? PH_W'(1) :
                 (r_ph > PH_W'(POOL_MAX)) ? PH_W'(POOL_MAX) : r_ph;
        cfg.pw = (r_pw == '0) ? PH_W'(1) :
                 (r_pw > PH_W'(POOL_MAX)) ? PH_W'(POOL_MAX) : r_pw;
        cfg.h  = (r_h == '0) ? H_W'(1) : (r_h > H_W'(H_MAX)) ? H_W'(H_MAX) : r_h;
        cfg.w  = (r_w == '0) ? W_W'(1) : (r_w > W_W'(W_MAX)) ? W_W'(W_MAX) : r_w;
        cfg.c  = (r_c == '0) ? C_W'(1) :
                 (r_c > C_W'(MAX_CHANNELS)) ? C_W'(MAX_CHANNELS) : r_c;
    end

    // Recompute sequencing: start in the cycle after a write, stay busy until done.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kick <= 1'b1;
            r_busy <= 1'b1;
        end else begin
            r_kick <= i_cfg_we;
            if (i_cfg_we) begin
                r_busy <= 1'b1;
            end else if (div_done && !r_kick) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign load = div_done && !r_kick;

    // Divider lanes: output height, output width, row and column positions.
    always_comb begin
        div_dividend[LANE_H]   = DIV_W'(cfg.h);
        div_dividend[LANE_W]   = DIV_W'(cfg.w);
        div_dividend[LANE_ROW] = DIV_W'(row);
        div_dividend[LANE_COL] = DIV_W'(col);
        div_divisor[LANE_H]    = cfg.ph;
        div_divisor[LANE_W]    = cfg.pw;
        div_divisor[LANE_ROW]  = cfg.ph;
        div_divisor[LANE_COL]  = cfg.pw;

        pos.out_h = div_quo[LANE_H];
        pos.out_w = W_W'(div_quo[LANE_W]);
        pos.row_q = ROW_W'(div_quo[LANE_ROW]);
        pos.row_r = WIN_W'(div_rem[LANE_ROW]);
        pos.col_q = COL_W'(div_quo[LANE_COL]);
        pos.col_r = WIN_W'(div_rem[LANE_COL]);
    end

    mp2s_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_kick),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // Input handshake.
    assign i_in.ready = !r_busy && !i_cfg_we && adv;
    assign accept     = i_in.valid && i_in.ready;

    mp2s_cnt u_cnt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_load   (load),
        .i_pos    (pos),
        .i_accept (accept),
        .i_item   (i_in.data),
        .o_req    (req),
        .o_row    (row),
        .o_col    (col)
    );

    mp2s_rmw u_rmw (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_req    (req),
        .o_adv    (adv),
        .o_out    (o_out)
    );

endmodule

>>> dv/tb_max_pooling_2d_stream_top.sv
// ============================================================================
// tb_max_pooling_2d_stream_top
// Self-checking testbench for the streaming 2-D max-pooling block. A short
// scripted sequence with hand-worked results is followed by random feature
// maps over many window and map shapes. Every accepted sample is run through
// a local model of the pooling windows, and each pooled value leaving the
// block is compared against the oldest outstanding prediction.
// ============================================================================
module tb_max_pooling_2d_stream_top;
    import mp2s_pkg::*;

    localparam int RANDOM_ITEMS   = 1315;
    localparam int MAP_CAP        = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    // Kinds of line in the scripted sequence.
    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_CHECKED,
        ROW_QUIET,
        ROW_TYPED
    } t_row_kind;

    typedef struct {
        t_row_kind   kind;
        t_cfg_idx    reg_idx;
        int unsigned reg_val;
        t_in_item    stim;
        t_out_item   typed;
    } t_script_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    mp2s_in_if  sample_ch ();
    mp2s_out_if pooled_ch ();

    max_pooling_2d_stream_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (sample_ch),
        .o_out      (pooled_ch)
    );

    // Clock with a period of four time units.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Local copy of the block's registers, counters and running maxima.
    logic [PH_W-1:0] raw_ph, raw_pw;
    logic [H_W-1:0]  raw_h;
    logic [W_W-1:0]  raw_w;
    logic [C_W-1:0]  raw_c;
    int unsigned     eff_ph, eff_pw, eff_h, eff_w, eff_c, rows_out, cols_out;
    int unsigned     row_pos, col_pos, chan_pos, row_win, col_win;

    logic signed [SAMPLE_BITS-1:0] win_max_mem [STORE_DEPTH];
    bit                            mem_written [STORE_DEPTH];

    t_out_item pending_maxima [$];

    int unsigned errors, samples_sent, used_items, results_checked;
    int unsigned cfg_writes, phase_count, quiet_cycles, sent_target;
    bit          tx_calm;

    // The scripted opening. The first two samples run under the reset shape
    // and close no window. With every size limited to one, each sample is its
    // own map and comes straight back. A 2x2 map then yields its maximum, and
    // the next map follows without a frame start and must reload its window.
    t_script_row script [35] = '{
        '{ROW_QUIET,   CFG_POOL_HEIGHT,   0, '{16'sh7FFF, 1'b1}, '{16'sh0000, 1'b0}},
        '{ROW_QUIET,   CFG_POOL_HEIGHT,   0, '{16'sh8000, 1'b0}, '{16'sh0000, 1'b0}},
        '{ROW_CFG,     CFG_POOL_HEIGHT,   1, '{16'sh0000, 1'b0}, '{16'sh0000, 1'b0}},
        '{ROW_CFG,     CFG_POOL_WIDTH,    0, '{16'sh0000, 1'b0}, '{16'sh0000, 1'b0}},
        '{ROW_CFG,     CFG_IN_HEIGHT,     0, '{16'sh0000, 1'b0}, '{16'sh0000, 1'b0}},
        '{ROW_CFG,     CFG_IN_WIDTH,      1, '{16'sh0000, 1'b0}, '{16'sh0000, 1'b0}},
        '{ROW_CFG,     CFG_CHANNEL_COUNT, 0, '{16'sh0000, 1'b0}, '{16'sh0000, 1'b0}},
        '{ROW_TYPED,   CFG_POOL_HEIGHT,   0, '{16'sh7FFF, 1'b1}, '{16'sh7FFF, 1'b1}},
        '{ROW_TYPED,   CFG_POOL_HEIGHT,   0, '{16'sh8000, 1'b0}, '{16'sh8000, 1'b1}},
        '{ROW_TYPED,   CFG_POOL_HEIGHT,   0, '{16'sh0000, 1'b1}, '{16'sh0000, 1'b1}},
        '{ROW_TYPED,   CFG_POOL_HEIGHT,   0, '{16'shFFFF, 1'b0}, '{16'shFFFF, 1'b1}},
        '{ROW_TYPED,   CFG_POOL_HEIGHT,   0, '{16'sh0001, 1'b0}, '{16'sh0001, 1'b1}},
        '{ROW_TYPED,   CFG_POOL_HEIGHT,   0, '{16'sh5555, 1'b0}, '{16'sh5555, 1'b1}},
        '{ROW_TYPED,   CFG_POOL_HEIGHT,   0, '{16'shAAAA, 1'b1}, '{16'shAAAA, 1'b1}},
        '{ROW_CFG,     CFG_POOL_HEIGHT,   2, '{16'sh0000, 1'b0}, '{16'sh0000, 1'b0}},
        '{ROW_CFG,     CFG_POOL_WIDTH,    2, '{16'sh0000, 1'b0}, '{16'sh0000, 1'b0}},
        '{ROW_CFG,     CFG_IN_HEIGHT,     2, '{16'sh0000, 1'b0}, '{16'sh0000, 1'b0}},
        '{ROW_CFG,     CFG_IN_WIDTH,      2, '{16'sh0000, 1'b0}, '{16'sh0000, 1'b0}},
        '{ROW_QUIET,   CFG_POOL_HEIGHT,   0, '{16'sh0064, 1'b1}, '{16'sh0000, 1'b0}},
        '{ROW_QUIET,   CFG_POOL_HEIGHT,   0, '{16'shFFFB, 1'b0}, '{16'sh0000, 1'b0}},
        '{ROW_QUIET,   CFG_POOL_HEIGHT,   0, '{16'sh012C, 1'b0}, '{16'sh0000, 1'b0}},
        '{ROW_TYPED,   CFG_POOL_HEIGHT,   0, '{16'sh0007, 1'b0}, '{16'sh012C, 1'b1}},
        '{ROW_QUIET,   CFG_POOL_HEIGHT,   0, '{16'sh8000, 1'b0}, '{16'sh0000, 1'b0}},
        '{ROW_QUIET,   CFG_POOL_HEIGHT,   0, '{16'sh8000, 1'b0}, '{16'sh0000, 1'b0}},
        '{ROW_QUIET,   CFG_POOL_HEIGHT,   0, '{16'sh8000, 1'b0}, '{16'sh0000, 1'b0}},
        '{ROW_TYPED,   CFG_POOL_HEIGHT,   0, '{16'sh8000, 1'b0}, '{16'sh8000, 1'b1}},
        '{ROW_CFG,     CFG_CHANNEL_COUNT, 2, '{16'sh0000, 1'b0}, '{16'sh0000, 1'b0}},
        '{ROW_CHECKED, CFG_POOL_HEIGHT,   0, '{16'sh0100, 1'b1}, '{16'sh0000, 1'b0}},
        '{ROW_CHECKED, CFG_POOL_HEIGHT,   0, '{16'shFF00, 1'b0}, '{16'sh0000, 1'b0}},
        '{ROW_CHECKED, CFG_POOL_HEIGHT,   0, '{16'sh0200, 1'b0}, '{16'sh0000, 1'b0}},
        '{ROW_CHECKED, CFG_POOL_HEIGHT,   0, '{16'sh8000, 1'b0}, '{16'sh0000, 1'b0}},
        '{ROW_CHECKED, CFG_POOL_HEIGHT,   0, '{16'sh7FFF, 1'b0}, '{16'sh0000, 1'b0}},
        '{ROW_CHECKED, CFG_POOL_HEIGHT,   0, '{16'sh0000, 1'b0}, '{16'sh0000, 1'b0}},
        '{ROW_CHECKED, CFG_POOL_HEIGHT,   0, '{16'shFFFF, 1'b0}, '{16'sh0000, 1'b0}},
        '{ROW_CHECKED, CFG_POOL_HEIGHT,   0, '{16'sh0300, 1'b0}, '{16'sh0000, 1'b0}}
    };

    function automatic int unsigned limit(input int unsigned v, input int unsigned lo,
                                          input int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Register write as the block sees it: masked to the register width,
    // then limited to the legal range when used.
    function automatic void apply_cfg(input t_cfg_idx idx, input int unsigned val);
        case (idx)
            CFG_POOL_HEIGHT:   raw_ph = val[PH_W-1:0];
            CFG_POOL_WIDTH:    raw_pw = val[PH_W-1:0];
            CFG_IN_HEIGHT:     raw_h  = val[H_W-1:0];
            CFG_IN_WIDTH:      raw_w  = val[W_W-1:0];
            CFG_CHANNEL_COUNT: raw_c  = val[C_W-1:0];
            default: ;
        endcase
        eff_ph   = limit(raw_ph, 1, POOL_MAX);
        eff_pw   = limit(raw_pw, 1, POOL_MAX);
        eff_h    = limit(raw_h, 1, H_MAX);
        eff_w    = limit(raw_w, 1, W_MAX);
        eff_c    = limit(raw_c, 1, MAX_CHANNELS);
        rows_out = eff_h / eff_ph;
        cols_out = eff_w / eff_pw;
    endfunction

    // Where the current position falls: returns whether the sample lies in a
    // whole window, with its store slot and its place in the window and map.
    function automatic bit locate_window(output int unsigned slot, output bit first,
                                         output bit last, output bit map_end);
        int unsigned out_col;
        out_col = col_pos / eff_pw;
        slot    = (out_col * MAX_CHANNELS + chan_pos) % STORE_DEPTH;
        first   = row_win == 0 && col_win == 0;
        last    = row_win == eff_ph - 1 && col_win == eff_pw - 1;
        map_end = row_pos == rows_out * eff_ph - 1 && out_col == cols_out - 1 &&
                  chan_pos == eff_c - 1;
        return row_pos < rows_out * eff_ph && col_pos < cols_out * eff_pw &&
               chan_pos < eff_c;
    endfunction

    // True when a sample without frame start would compare against a store
    // entry that no window has ever loaded.
    function automatic bit hits_unwritten();
        int unsigned slot;
        bit first, last, map_end;
        if (!locate_window(slot, first, last, map_end)) return 1'b0;
        return !first && !mem_written[slot];
    endfunction

    // Takes one sample into the local pooling state and returns whether it
    // closes a window, with the pooled value it produces.
    function automatic bit predict_window_max(input t_in_item item, output t_out_item res);
        int unsigned slot;
        bit first, last, map_end;
        predict_window_max = 1'b0;
        res = '0;
        if (item.frame_start) begin
            row_pos  = 0;
            col_pos  = 0;
            chan_pos = 0;
            row_win  = 0;
            col_win  = 0;
        end
        if (locate_window(slot, first, last, map_end)) begin
            used_items++;
            if (first || item.sample > win_max_mem[slot]) begin
                win_max_mem[slot] = item.sample;
                mem_written[slot] = 1'b1;
            end
            if (last) begin
                res.pooled_value   = win_max_mem[slot];
                res.frame_last     = map_end;
                predict_window_max = 1'b1;
            end
        end
        // Channel fastest, then column, then row; the window counters follow.
        chan_pos++;
        if (chan_pos >= eff_c) begin
            chan_pos = 0;
            col_win++;
            if (col_win >= eff_pw) col_win = 0;
            col_pos++;
            if (col_pos >= eff_w) begin
                col_pos = 0;
                col_win = 0;
                row_win++;
                if (row_win >= eff_ph) row_win = 0;
                row_pos++;
                if (row_pos >= eff_h) begin
                    row_pos = 0;
                    row_win = 0;
                end
            end
        end
    endfunction

    // Idle length: mostly short, now and then long.
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 65) return $urandom_range(1, 2);
        if (r < 93) return $urandom_range(3, 7);
        return $urandom_range(12, 30);
    endfunction

    // Register value that is below, above or inside the legal range.
    function automatic int unsigned pick_reg(input int unsigned normal_hi,
                                             input int unsigned over_lo,
                                             input int unsigned over_hi);
        case ($urandom_range(2))
            0:       return 0;
            1:       return $urandom_range(over_lo, over_hi);
            default: return $urandom_range(1, normal_hi);
        endcase
    endfunction

    // One write on the configuration port.
    task automatic write_reg(input t_cfg_idx idx, input int unsigned val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val[CFG_DATA_W-1:0];
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        apply_cfg(idx, val);
        cfg_writes++;
    endtask

    // Offers one sample after a random gap and books its outcome once the
    // transaction completes.
    task automatic send_sample(input t_in_item item, input t_row_kind kind,
                               input t_out_item typed);
        int unsigned gap;
        t_out_item   got;
        bit          made;
        gap = (tx_calm || $urandom_range(1) == 0) ? 0 : idle_len();
        if (gap != 0) begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.data  <= item;
        @(posedge i_clk);
        while (!sample_ch.ready) @(posedge i_clk);
        samples_sent++;
        made = predict_window_max(item, got);
        if (kind == ROW_TYPED) begin
            pending_maxima.push_back(typed);
        end else if (kind == ROW_CHECKED && made) begin
            pending_maxima.push_back(got);
        end
    endtask

    // Lets every outstanding pooled value drain, then allows for write-back.
    task automatic settle();
        sample_ch.valid <= 1'b0;
        while (pending_maxima.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One random phase: a fresh shape, then a few maps of random content.
    task automatic random_phase();
        int unsigned ph, pw, h, w, c, pick, map_len, maps, len, val;
        bit          fresh, fs;
        t_in_item    item;
        pick = $urandom_range(99);
        if (pick < 65) begin
            ph = $urandom_range(1, 4);
            pw = $urandom_range(1, 4);
            h  = $urandom_range(1, 9);
            w  = $urandom_range(1, 12);
            c  = $urandom_range(1, 4);
        end else if (pick < 80) begin
            case ($urandom_range(5))
                0:       begin ph = 16; pw = 16; h = 16;   w = 16;  c = 1;  end
                1:       begin ph = 1;  pw = 16; h = 1;    w = 256; c = 1;  end
                2:       begin ph = 2;  pw = 2;  h = 2;    w = 2;   c = 32; end
                3:       begin ph = 1;  pw = 1;  h = 4096; w = 1;   c = 1;  end
                4:       begin ph = 16; pw = 2;  h = 17;   w = 5;   c = 2;  end
                default: begin ph = 1;  pw = 1;  h = 1;    w = 256; c = 1;  end
            endcase
        end else if (pick < 90) begin
            ph = pick_reg(4, POOL_MAX + 1, 31);
            pw = pick_reg(4, POOL_MAX + 1, 31);
            h  = pick_reg(9, H_MAX + 1, 8191);
            w  = pick_reg(12, W_MAX + 1, 511);
            c  = pick_reg(4, MAX_CHANNELS + 1, 63);
        end else begin
            // Map smaller than the window in one dimension: nothing comes out.
            ph = $urandom_range(3, 6);
            pw = $urandom_range(3, 6);
            if ($urandom_range(1) == 0) begin
                h = $urandom_range(1, ph - 1);
                w = $urandom_range(1, 12);
            end else begin
                h = $urandom_range(1, 9);
                w = $urandom_range(1, pw - 1);
            end
            c = $urandom_range(1, 3);
        end

        settle();
        write_reg(CFG_POOL_HEIGHT, ph);
        write_reg(CFG_POOL_WIDTH, pw);
        write_reg(CFG_IN_HEIGHT, h);
        write_reg(CFG_IN_WIDTH, w);
        write_reg(CFG_CHANNEL_COUNT, c);
        phase_count++;

        // Most phases restart the map; the rest carry on from the old position.
        fresh   = $urandom_range(4) != 0;
        tx_calm = $urandom_range(3) == 0;
        map_len = eff_h * eff_w * eff_c;
        if (map_len > MAP_CAP) map_len = MAP_CAP;
        maps = (map_len <= 40) ? $urandom_range(2, 5) : 1;

        for (int m = 0; m < maps; m++) begin
            // One map in ten is cut short.
            len = ($urandom_range(9) == 0) ? $urandom_range(1, map_len) : map_len;
            for (int k = 0; k < len && samples_sent < sent_target; k++) begin
                if (k == 0) fs = (m == 0) ? fresh : $urandom_range(1);
                else fs = $urandom_range(99) == 0;
                if (!fs && hits_unwritten()) fs = 1'b1;
                pick = $urandom_range(99);
                val  = $urandom();
                if (pick < 6) item.sample = 16'sh7FFF;
                else if (pick < 12) item.sample = 16'sh8000;
                else if (pick < 16) item.sample = {16{val[0]}};
                else item.sample = val[SAMPLE_BITS-1:0];
                item.frame_start = fs;
                send_sample(item, ROW_CHECKED, '0);
            end
        end
    endtask

    // Stimulus: reset, the scripted opening, then random phases.
    initial begin : stimulus
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = CFG_POOL_HEIGHT;
        cfg_data        = '0;
        sample_ch.valid = 1'b0;
        sample_ch.data  = '0;
        tx_calm         = 1'b0;
        apply_cfg(CFG_POOL_HEIGHT, RST_POOL);
        apply_cfg(CFG_POOL_WIDTH, RST_POOL);
        apply_cfg(CFG_IN_HEIGHT, RST_SIZE);
        apply_cfg(CFG_IN_WIDTH, RST_SIZE);
        apply_cfg(CFG_CHANNEL_COUNT, RST_CHANNELS);
        row_pos  = 0;
        col_pos  = 0;
        chan_pos = 0;
        row_win  = 0;
        col_win  = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < $size(script); i++) begin
            if (script[i].kind == ROW_CFG) begin
                if (i == 0 || script[i-1].kind != ROW_CFG) settle();
                write_reg(script[i].reg_idx, script[i].reg_val);
            end else begin
                send_sample(script[i].stim, script[i].kind, script[i].typed);
            end
        end

        // Random phases until the sample budget is spent.
        sent_target = samples_sent + RANDOM_ITEMS;
        while (samples_sent < sent_target)
            random_phase();

        settle();
        $display("Sent %0d samples, %0d of them inside whole windows, over %0d random shapes",
                 samples_sent, used_items, phase_count);
        $display("and %0d register writes; %0d pooled values were checked.",
                 cfg_writes, results_checked);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Output side: ready with random stalls, and stretches without them.
    initial begin : pooled_sink
        int unsigned hold;
        bit          calm;
        hold            = 0;
        calm            = 1'b0;
        pooled_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if ($urandom_range(199) == 0) calm = !calm;
            if (hold != 0) begin
                hold--;
                pooled_ch.ready <= 1'b0;
            end else begin
                pooled_ch.ready <= 1'b1;
                if (!calm && $urandom_range(99) < 25) hold = idle_len();
            end
        end
    end

    // Each pooled value is checked against the oldest outstanding prediction.
    always @(posedge i_clk) begin : pooled_check
        t_out_item want;
        if (i_rst_n && pooled_ch.valid && pooled_ch.ready) begin
            if (pending_maxima.size() == 0) begin
                errors++;
                $display("%0t: unexpected pooled value %0d (last %0b)", $time,
                         pooled_ch.data.pooled_value, pooled_ch.data.frame_last);
            end else begin
                want = pending_maxima.pop_front();
                results_checked++;
                if (pooled_ch.data.pooled_value !== want.pooled_value) begin
                    errors++;
                    $display("%0t: pooled value: expected %0d, actual %0d", $time,
                             want.pooled_value, pooled_ch.data.pooled_value);
                end
                if (pooled_ch.data.frame_last !== want.frame_last) begin
                    errors++;
                    $display("%0t: frame last flag: expected %0b, actual %0b", $time,
                             want.frame_last, pooled_ch.data.frame_last);
                end
            end
        end
    end

    // Watchdog: ends the run if no transaction completes for too long.
    always @(posedge i_clk) begin
        if ((sample_ch.valid && sample_ch.ready) || (pooled_ch.valid && pooled_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d pooled values outstanding",
                     $time, WATCHDOG_LIMIT, pending_maxima.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule

>>> filelist.f
hw/rtl/mp2s_pkg.sv
hw/rtl/mp2s_in_if.sv
hw/rtl/mp2s_out_if.sv
hw/rtl/mp2s_div.sv
hw/rtl/mp2s_cnt.sv
hw/rtl/mp2s_rmw.sv
hw/rtl/max_pooling_2d_stream_top.sv
dv/tb_max_pooling_2d_stream_top.sv
